[hw/rtl/ffba_pkg.sv]
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int ARENA_BYTES = 1048576;
    localparam int MAX_BLOCKS  = 64;

    localparam int ADDR_W  = 20;
    localparam int SIZE_W  = 21;
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int ENTRY_W = ADDR_W + SIZE_W;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_REALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE    = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [ADDR_W-1:0] block_addr;
        logic [SIZE_W-1:0] req_size;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0] result_addr;
        logic [2:0]        status;
        logic              moved;
        logic [SIZE_W-1:0] copy_len;
    } t_rsp;

endpackage

[hw/rtl/ffba_ram.sv]
// Generic simple dual-port RAM with a registered read.
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/first_fit_block_allocator.sv]
// First-fit block allocator: top level with the table sequencer.
//
// The block keeps the live blocks of a byte arena in one RAM, sorted by start
// offset, and serves one request at a time: allocate, reallocate or free. An
// allocate scans the table in order, one entry per cycle, and stops at the
// first gap that fits; the entries behind the insertion point are then moved
// up one place, again one per cycle. A free looks up the block and moves the
// entries behind it down. A reallocate looks up the block, resizes it in place
// when it still fits before its neighbor or the limit, and otherwise places a
// new block, removes the old one and reports the move with the copy length.
// The single RAM port pair moves one entry per cycle, so the work of a request
// grows with the number of live blocks. A new request beat is taken while the
// previous result beat still waits.
module first_fit_block_allocator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  ffba_pkg::t_req             i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output ffba_pkg::t_rsp             o_out,
    input  logic                       i_cfg_we,
    input  logic [ffba_pkg::SIZE_W-1:0] i_cfg_data
);
    import ffba_pkg::*;

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1; // look up the block by start offset
    localparam logic [2:0] S_BCHK  = 3'd2; // check in-place resize
    localparam logic [2:0] S_PLACE = 3'd3; // first-fit scan
    localparam logic [2:0] S_SHUP  = 3'd4; // open a slot, then write new entry
    localparam logic [2:0] S_SHDN  = 3'd5; // close the slot of a removed entry
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic [SIZE_W-1:0] LIM_MAX = SIZE_W'(ARENA_BYTES);
    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);

    logic [2:0]        r_state, n_state;
    logic [1:0]        r_type;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] r_limit;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_ptr, n_ptr;   // next RAM index to read
    logic              r_pv, n_pv;     // a read is in flight
    logic [CNT_W-1:0]  r_pi, n_pi;     // index tied to the read in flight
    logic [SIZE_W-1:0] r_cand, n_cand; // current first-fit candidate offset
    logic [CNT_W-1:0]  r_pos, n_pos;
    logic [ADDR_W-1:0] r_naddr, n_naddr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0] r_bstart, n_bstart;
    logic [SIZE_W-1:0] r_old, n_old;
    t_rsp              r_res, n_res;
    t_rsp              r_out;
    logic              r_ovld;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [ADDR_W-1:0] rd_start;
    logic [SIZE_W-1:0] rd_size;
    logic [SIZE_W-1:0] lim;
    logic [SIZE_W:0]   cand_end;
    logic [SIZE_W:0]   inplace_end;
    logic [SIZE_W:0]   bound;
    logic [CNT_W-1:0]  ptr_dec;
    logic [CNT_W-1:0]  idx_adj;
    logic              accept;
    logic              out_free;

    ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[ENTRY_W-1:SIZE_W];
    assign rd_size  = ram_rdata[SIZE_W-1:0];

    // A limit above the arena size acts as the arena size.
    assign lim         = (r_limit > LIM_MAX) ? LIM_MAX : r_limit;
    assign cand_end    = {1'b0, r_cand} + {1'b0, r_size};
    assign inplace_end = {2'b00, r_bstart} + {1'b0, r_size};
    assign ptr_dec     = r_ptr - CNT_W'(1);
    assign idx_adj     = (r_pos <= r_idx) ? r_idx + CNT_W'(1) : r_idx;

    // The read of the entry after the found block was issued in the same
    // cycle as the hit, so its data is on the RAM output in S_BCHK.
    assign bound = ((r_idx + CNT_W'(1)) < r_count) ? {2'b00, rd_start} : {1'b0, lim};

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_ovld || i_out_ready;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_pv     = 1'b0;
        n_pi     = r_pi;
        n_cand   = r_cand;
        n_pos    = r_pos;
        n_naddr  = r_naddr;
        n_idx    = r_idx;
        n_bstart = r_bstart;
        n_old    = r_old;
        n_res    = r_res;
        ram_we    = 1'b0;
        ram_waddr = r_pi[IDX_W-1:0];
        ram_wdata = ram_rdata;
        ram_raddr = r_ptr[IDX_W-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res  = '0;
                    n_ptr  = '0;
                    n_cand = '0;
                    case (i_in.req_type)
                        REQ_ALLOC: begin
                            if (i_in.req_size == '0) begin
                                n_res.status = ST_ZERO;
                                n_state      = S_DONE;
                            end else if (r_count >= CNT_MAX) begin
                                n_res.status = ST_FULL;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_PLACE;
                            end
                        end
                        REQ_REALLOC: begin
                            if (i_in.req_size == '0) begin
                                n_res.status = ST_ZERO;
                                n_state      = S_DONE;
                            end else begin
                                n_state = S_FIND;
                            end
                        end
                        REQ_FREE: begin
                            n_state = S_FIND;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND: begin
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + CNT_W'(1);
                    n_pv  = 1'b1;
                    n_pi  = r_ptr;
                end
                if (r_pv) begin
                    if (rd_start == r_addr) begin
                        n_idx    = r_pi;
                        n_bstart = rd_start;
                        n_old    = rd_size;
                        n_pv     = 1'b0;
                        if (r_type == REQ_FREE) begin
                            n_ptr   = r_pi + CNT_W'(1);
                            n_state = S_SHDN;
                        end else begin
                            n_state = S_BCHK;
                        end
                    end
                end else if (r_ptr >= r_count) begin
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_DONE;
                end
            end

            S_BCHK: begin
                n_ptr  = '0;
                n_cand = '0;
                if (inplace_end <= bound) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_idx[IDX_W-1:0];
                    ram_wdata = {r_bstart, r_size};
                    n_res.result_addr = r_bstart;
                    n_state   = S_DONE;
                end else if (r_count >= CNT_MAX) begin
                    n_res.status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                if (r_ptr < r_count) begin
                    n_ptr = r_ptr + CNT_W'(1);
                    n_pv  = 1'b1;
                    n_pi  = r_ptr;
                end
                if (r_pv) begin
                    if (cand_end <= {2'b00, rd_start} && cand_end <= {1'b0, lim}) begin
                        n_pos   = r_pi;
                        n_naddr = r_cand[ADDR_W-1:0];
                        n_ptr   = r_count;
                        n_pv    = 1'b0;
                        n_state = S_SHUP;
                    end else begin
                        n_cand = SIZE_W'({1'b0, rd_start} + rd_size);
                    end
                end else if (r_ptr >= r_count) begin
                    if (cand_end <= {1'b0, lim}) begin
                        n_pos   = r_count;
                        n_naddr = r_cand[ADDR_W-1:0];
                        n_ptr   = r_count;
                        n_state = S_SHUP;
                    end else begin
                        n_res.status = ST_NOSPACE;
                        n_state      = S_DONE;
                    end
                end
            end

            // r_ptr is the slot that receives the entry below it.
            S_SHUP: begin
                if (r_ptr > r_pos) begin
                    ram_raddr = ptr_dec[IDX_W-1:0];
                    n_pi      = r_ptr;
                    n_pv      = 1'b1;
                    n_ptr     = ptr_dec;
                end
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pi[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end else if (r_ptr == r_pos) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[IDX_W-1:0];
                    ram_wdata = {r_naddr, r_size};
                    n_count   = r_count + CNT_W'(1);
                    n_res.result_addr = r_naddr;
                    if (r_type == REQ_REALLOC) begin
                        n_res.moved    = 1'b1;
                        n_res.copy_len = (r_old < r_size) ? r_old : r_size;
                        n_idx          = idx_adj;
                        n_ptr          = idx_adj + CNT_W'(1);
                        n_state        = S_SHDN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            // r_ptr is the entry that moves down into the slot below it.
            S_SHDN: begin
                if (r_ptr < r_count) begin
                    n_pi  = ptr_dec;
                    n_pv  = 1'b1;
                    n_ptr = r_ptr + CNT_W'(1);
                end
                if (r_pv) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pi[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end else if (r_ptr >= r_count) begin
                    n_count = r_count - CNT_W'(1);
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_limit <= LIM_MAX;
            r_pv    <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_type <= i_in.req_type;
            r_addr <= i_in.block_addr;
            r_size <= i_in.req_size;
        end
        if (r_state == S_DONE && out_free) begin
            r_out <= r_res;
        end
        r_ptr    <= n_ptr;
        r_pi     <= n_pi;
        r_cand   <= n_cand;
        r_pos    <= n_pos;
        r_naddr  <= n_naddr;
        r_idx    <= n_idx;
        r_bstart <= n_bstart;
        r_old    <= n_old;
        r_res    <= n_res;
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

`ifndef ASSERT_OFF
    // The table never holds more blocks than it has entries.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count exceeds table depth");

    // The table is written only while a request is being worked on.
    a_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_BCHK || r_state == S_SHUP || r_state == S_SHDN))
        else $error("table written outside a request");

    // A failed request reports no address and no move.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != ST_OK) |->
            (o_out.result_addr == '0 && !o_out.moved && o_out.copy_len == '0))
        else $error("error result carries payload");

    // A moving resize always reports a nonzero copy length.
    a_move_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.moved) |-> (o_out.copy_len != '0))
        else $error("move without copy length");
`endif
endmodule
